@@ hw/rtl/sdks_pkg.sv @@
// shared types, constants and key function for the date key sort core
package sdks_pkg;

   localparam int KEY_W   = 20;
   localparam int IDX_W   = 9;
   localparam int DIGIT_W = 4;
   localparam int OP_W    = 2;
   localparam int POS_W   = 9;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // broadcast from the control stage to every cell
   typedef struct packed {
      logic             ins;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] idx;
   } bcast_type;

   // yymmdd from raw digits, truncated to the key width
   function automatic logic [KEY_W-1:0] date_key(
      input logic [DIGIT_W-1:0] day_tens,
      input logic [DIGIT_W-1:0] day_ones,
      input logic [DIGIT_W-1:0] month_tens,
      input logic [DIGIT_W-1:0] month_ones,
      input logic [DIGIT_W-1:0] year_tens,
      input logic [DIGIT_W-1:0] year_ones
   );
      logic [23:0] sum;
      sum = 24'(year_tens)  * 24'd100000 + 24'(year_ones)  * 24'd10000
          + 24'(month_tens) * 24'd1000   + 24'(month_ones) * 24'd100
          + 24'(day_tens)   * 24'd10     + 24'(day_ones);
      return sum[KEY_W-1:0];
   endfunction

endpackage

@@ hw/rtl/stable_date_key_sort_core.sv @@
// top level of the stable date key sort core
// Records are kept sorted by yymmdd key in a chain of MAX_RECORDS cells; an append
// compares the new key against every cell at once and the larger entries all shift
// up one cell in the same clock, so equal keys stay in arrival order. One request
// is taken per cycle while the input is not stalled: a request is registered once
// in the request stage (key formed there) and then applied to the chain, and a query
// response passes from that stage into the response register. The input stalls
// only while a query waits behind a response that has not yet been taken. Appends
// to a full store and opcode three are dropped; clear only resets the record count.
module stable_date_key_sort_core #(
   parameter int MAX_RECORDS = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sdks_pkg::OP_W-1:0]    req_opcode,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_day_tens,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_day_ones,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_month_tens,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_month_ones,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_year_tens,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_year_ones,
   input  logic [sdks_pkg::POS_W-1:0]   req_position,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sdks_pkg::IDX_W-1:0]   rsp_original_index,
   output logic                         rsp_out_of_range
);

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);
   localparam int AW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int EXT_W = (AW > sdks_pkg::POS_W) ? AW : sdks_pkg::POS_W;
   localparam int CMP_W = (EXT_W > CNT_W) ? EXT_W : CNT_W;

   // request stage
   logic                          stage_valid_ff, stage_valid_in;
   logic [sdks_pkg::OP_W-1:0]     stage_op_ff, stage_op_in;
   logic [sdks_pkg::KEY_W-1:0]    stage_key_ff, stage_key_in;
   logic [sdks_pkg::POS_W-1:0]    stage_pos_ff, stage_pos_in;

   logic [CNT_W-1:0]              count_ff, count_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sdks_pkg::IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                          rsp_oor_ff, rsp_oor_in;

   logic                          advance, accept, fire;
   logic                          is_query, is_append, is_clear;
   logic                          store_full, in_range;
   logic [EXT_W-1:0]              pos_wide;
   logic [AW-1:0]                 rd_addr;

   sdks_pkg::bcast_type           bcast;

   logic                          cell_gt  [MAX_RECORDS];
   logic [sdks_pkg::KEY_W-1:0]    cell_key [MAX_RECORDS];
   logic [sdks_pkg::IDX_W-1:0]    cell_idx [MAX_RECORDS];

   assign is_query  = (stage_op_ff == sdks_pkg::OP_QUERY);
   assign is_append = (stage_op_ff == sdks_pkg::OP_APPEND);
   assign is_clear  = (stage_op_ff == sdks_pkg::OP_CLEAR);

   // only a query needs the response register
   assign advance   = !(stage_valid_ff && is_query && rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign fire      = stage_valid_ff && advance;

   assign store_full = (count_ff == CNT_W'(MAX_RECORDS));

   assign bcast.ins = fire && is_append && !store_full;
   assign bcast.key = stage_key_ff;
   assign bcast.idx = sdks_pkg::IDX_W'(count_ff);

   genvar i;
   generate
      for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
         logic                       occ;
         logic                       pgt;
         logic [sdks_pkg::KEY_W-1:0] pkey;
         logic [sdks_pkg::IDX_W-1:0] pidx;

         assign occ = (count_ff > CNT_W'(i));
         if (i == 0) begin : g_head
            assign pgt  = 1'b0;
            assign pkey = '0;
            assign pidx = '0;
         end else begin : g_body
            assign pgt  = cell_gt[i-1];
            assign pkey = cell_key[i-1];
            assign pidx = cell_idx[i-1];
         end

         sdks_cell u_cell (
            .clock    (clock),
            .bcast    (bcast),
            .occupied (occ),
            .prev_gt  (pgt),
            .prev_key (pkey),
            .prev_idx (pidx),
            .gt       (cell_gt[i]),
            .key      (cell_key[i]),
            .idx      (cell_idx[i])
         );
      end
   endgenerate

   assign pos_wide = EXT_W'(stage_pos_ff);
   assign rd_addr  = pos_wide[AW-1:0];
   assign in_range = (CMP_W'(stage_pos_ff) < CMP_W'(count_ff));

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_op_in    = stage_op_ff;
      stage_key_in   = stage_key_ff;
      stage_pos_in   = stage_pos_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
         stage_op_in    = req_opcode;
         stage_key_in   = sdks_pkg::date_key(req_day_tens, req_day_ones, req_month_tens,
                                             req_month_ones, req_year_tens, req_year_ones);
         stage_pos_in   = req_position;
      end else if (fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (fire) begin
         if (is_clear) begin
            count_in = '0;
         end else if (is_append && !store_full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (fire && is_query) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = in_range ? cell_idx[rd_addr] : '0;
         rsp_oor_in   = !in_range;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_op_ff  <= stage_op_in;
      stage_key_ff <= stage_key_in;
      stage_pos_ff <= stage_pos_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_original_index = rsp_idx_ff;
   assign rsp_out_of_range   = rsp_oor_ff;

endmodule

@@ hw/rtl/sdks_cell.sv @@
// one cell of the insertion chain: holds a key and its arrival index
module sdks_cell (
   input  logic                     clock,
   input  sdks_pkg::bcast_type      bcast,
   input  logic                     occupied,
   input  logic                     prev_gt,
   input  logic [sdks_pkg::KEY_W-1:0] prev_key,
   input  logic [sdks_pkg::IDX_W-1:0] prev_idx,
   output logic                     gt,
   output logic [sdks_pkg::KEY_W-1:0] key,
   output logic [sdks_pkg::IDX_W-1:0] idx
);

   logic [sdks_pkg::KEY_W-1:0] key_ff, key_in;
   logic [sdks_pkg::IDX_W-1:0] idx_ff, idx_in;

   // an empty cell counts as larger than any key
   assign gt = !occupied || (key_ff > bcast.key);

   always_comb begin
      key_in = key_ff;
      idx_in = idx_ff;
      if (bcast.ins && gt) begin
         // first larger cell takes the new record, the rest shift up
         if (prev_gt) begin
            key_in = prev_key;
            idx_in = prev_idx;
         end else begin
            key_in = bcast.key;
            idx_in = bcast.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      idx_ff <= idx_in;
   end

   assign key = key_ff;
   assign idx = idx_ff;

endmodule

@@ hw/rtl/sdks_checker.sv @@
// port checker for the date key sort core, bound to the top level
module sdks_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [sdks_pkg::OP_W-1:0]    req_opcode,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sdks_pkg::IDX_W-1:0]   rsp_original_index,
   input logic                         rsp_out_of_range
);

   logic query_accept;
   assign query_accept = req_valid && !req_stall && (req_opcode == sdks_pkg::OP_QUERY);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_original_index)
                                 && $stable(rsp_out_of_range))
      else $error("response changed while stalled");

   // out of range responses carry index zero
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_original_index == '0)
      else $error("out of range response with nonzero index");

   // the input only stalls behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // a new response follows an accepted query request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(query_accept, 2))
      else $error("response without a query request");

endmodule

bind stable_date_key_sort_core sdks_checker u_sdks_checker (.*);

@@ tb/sdks_checker.sv @@
// watches both channels of the date key sort core, tracks its sorted store and checks every answer
`timescale 1ns / 1ps

module sdks_monitor #(
   parameter int MAX_RECORDS = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [sdks_pkg::OP_W-1:0]    req_opcode,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_day_tens,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_day_ones,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_month_tens,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_month_ones,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_year_tens,
   input  logic [sdks_pkg::DIGIT_W-1:0] req_year_ones,
   input  logic [sdks_pkg::POS_W-1:0]   req_position,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [sdks_pkg::IDX_W-1:0]   rsp_original_index,
   input  logic                         rsp_out_of_range,
   output int                           failures,
   output int                           answers_waiting
);

   typedef struct packed {
      logic [sdks_pkg::IDX_W-1:0] index;
      logic                       out_of_range;
   } answer_type;

   // shadow of the sorted store
   logic [sdks_pkg::KEY_W-1:0] shadow_keys  [MAX_RECORDS];
   logic [sdks_pkg::IDX_W-1:0] shadow_index [MAX_RECORDS];
   int unsigned                shadow_count;

   answer_type query_answers [$];
   int         mismatch_total;

   always @(posedge clock) begin : watch
      answer_type                 seen;
      answer_type                 due;
      logic [sdks_pkg::KEY_W-1:0] key;
      int unsigned                total;
      int                         p;
      bit                         bad;
      if (reset) begin
         shadow_count = 0;
         query_answers.delete();
         mismatch_total = 0;
      end else begin
         if (req_valid && !req_stall) begin
            unique case (req_opcode)
               sdks_pkg::OP_APPEND: begin
                  total = 32'(req_year_tens) * 100000 + 32'(req_year_ones) * 10000
                        + 32'(req_month_tens) * 1000 + 32'(req_month_ones) * 100
                        + 32'(req_day_tens) * 10 + 32'(req_day_ones);
                  key = total[sdks_pkg::KEY_W-1:0];
                  // appends to a full store are dropped
                  if (shadow_count < MAX_RECORDS) begin
                     p = shadow_count;
                     // strictly larger keys move up, equal keys stay ahead
                     while (p > 0 && shadow_keys[p-1] > key) begin
                        shadow_keys[p]  = shadow_keys[p-1];
                        shadow_index[p] = shadow_index[p-1];
                        p--;
                     end
                     shadow_keys[p]  = key;
                     shadow_index[p] = sdks_pkg::IDX_W'(shadow_count);
                     shadow_count++;
                  end
               end
               sdks_pkg::OP_QUERY: begin
                  if (req_position < shadow_count)
                     query_answers.push_back('{shadow_index[req_position], 1'b0});
                  else
                     query_answers.push_back('{'0, 1'b1});
               end
               sdks_pkg::OP_CLEAR: begin
                  shadow_count = 0;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_original_index, rsp_out_of_range};
            if (query_answers.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: answer index %0d out_of_range %0b with no query waiting",
                           $time, seen.index, seen.out_of_range);
            end else begin
               due = query_answers.pop_front();
               bad = 1'b0;
               if (seen.index !== due.index) bad = 1'b1;
               if (seen.out_of_range !== due.out_of_range) bad = 1'b1;
               if (bad) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display("%0t: index exp %0d got %0d, out_of_range exp %0b got %0b",
                              $time, due.index, seen.index, due.out_of_range,
                              seen.out_of_range);
               end
            end
         end
      end
      failures        <= mismatch_total;
      answers_waiting <= query_answers.size();
   end

endmodule

@@ tb/stable_date_key_sort_core_test.sv @@
// top of the date key sort core test: clock, reset, request and answer traffic, verdict
`timescale 1ns / 1ps

module stable_date_key_sort_core_test;

   localparam int MAX_RECORDS = 512;
   localparam int LIMIT       = 100000;
   localparam int HOLD_CYCLES = 300;

   localparam logic [sdks_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic [sdks_pkg::OP_W-1:0]    op;
      logic [sdks_pkg::DIGIT_W-1:0] dt, d1, mt, m1, yt, y1;
      logic [sdks_pkg::POS_W-1:0]   pos;
   } request_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [sdks_pkg::OP_W-1:0]     req_opcode;
   logic [sdks_pkg::DIGIT_W-1:0]  req_day_tens;
   logic [sdks_pkg::DIGIT_W-1:0]  req_day_ones;
   logic [sdks_pkg::DIGIT_W-1:0]  req_month_tens;
   logic [sdks_pkg::DIGIT_W-1:0]  req_month_ones;
   logic [sdks_pkg::DIGIT_W-1:0]  req_year_tens;
   logic [sdks_pkg::DIGIT_W-1:0]  req_year_ones;
   logic [sdks_pkg::POS_W-1:0]    req_position;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [sdks_pkg::IDX_W-1:0]    rsp_original_index;
   logic                          rsp_out_of_range;
   int                            failures;
   int                            answers_waiting;

   logic        hold_go;
   bit          no_gaps;
   int unsigned stored;
   int unsigned cycles;

   stable_date_key_sort_core #(.MAX_RECORDS(MAX_RECORDS)) i_dut (.*);

   sdks_monitor #(.MAX_RECORDS(MAX_RECORDS)) i_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic request_type date_req(
      input logic [sdks_pkg::DIGIT_W-1:0] dt, d1, mt, m1, yt, y1);
      request_type r;
      r = '{sdks_pkg::OP_APPEND, dt, d1, mt, m1, yt, y1,
            sdks_pkg::POS_W'($urandom_range(511))};
      return r;
   endfunction

   function automatic request_type plain_req(input logic [sdks_pkg::OP_W-1:0] op);
      request_type r;
      r.op  = op;
      r.dt  = sdks_pkg::DIGIT_W'($urandom_range(15));
      r.d1  = sdks_pkg::DIGIT_W'($urandom_range(15));
      r.mt  = sdks_pkg::DIGIT_W'($urandom_range(15));
      r.m1  = sdks_pkg::DIGIT_W'($urandom_range(15));
      r.yt  = sdks_pkg::DIGIT_W'($urandom_range(15));
      r.y1  = sdks_pkg::DIGIT_W'($urandom_range(15));
      r.pos = sdks_pkg::POS_W'($urandom_range(511));
      return r;
   endfunction

   function automatic request_type query_req(input int pos);
      request_type r;
      r     = plain_req(sdks_pkg::OP_QUERY);
      r.pos = sdks_pkg::POS_W'(pos);
      return r;
   endfunction

   // narrow dates land on a handful of keys so equal keys pile up
   function automatic request_type calendar_req(input bit narrow);
      int d, m, y;
      d = narrow ? $urandom_range(1, 3)   : $urandom_range(1, 31);
      m = narrow ? $urandom_range(1, 2)   : $urandom_range(1, 12);
      y = narrow ? $urandom_range(24, 25) : $urandom_range(0, 99);
      return date_req(sdks_pkg::DIGIT_W'(d / 10), sdks_pkg::DIGIT_W'(d % 10),
                      sdks_pkg::DIGIT_W'(m / 10), sdks_pkg::DIGIT_W'(m % 10),
                      sdks_pkg::DIGIT_W'(y / 10), sdks_pkg::DIGIT_W'(y % 10));
   endfunction

   function automatic request_type random_append();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return calendar_req(1'b1);
      if (pick < 90) return calendar_req(1'b0);
      return plain_req(sdks_pkg::OP_APPEND);
   endfunction

   function automatic request_type random_query();
      if (stored > 0 && $urandom_range(99) < 80)
         return query_req($urandom_range(stored - 1));
      return query_req($urandom_range(511));
   endfunction

   task automatic offer(input request_type r);
      if (!no_gaps) begin
         while ($urandom_range(99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_opcode     <= r.op;
      req_day_tens   <= r.dt;
      req_day_ones   <= r.d1;
      req_month_tens <= r.mt;
      req_month_ones <= r.m1;
      req_year_tens  <= r.yt;
      req_year_ones  <= r.y1;
      req_position   <= r.pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.op == sdks_pkg::OP_APPEND && stored < MAX_RECORDS) stored++;
      if (r.op == sdks_pkg::OP_CLEAR) stored = 0;
   endtask

   // answer side: random stalls, one quiet window, one long hold-off on request
   initial begin : receiver
      int  rcv_cycle;
      int  hold_left;
      bit  hold_used;
      rcv_cycle = 0;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         rcv_cycle++;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (rcv_cycle >= 1200 && rcv_cycle < 1800) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 31);
         end
      end
   end

   initial begin : stimulus
      int          n;
      int          random_items;
      request_type r;
      reset          <= 1'b1;
      hold_go        <= 1'b0;
      req_valid      <= 1'b0;
      req_opcode     <= sdks_pkg::OP_CLEAR;
      req_day_tens   <= '0;
      req_day_ones   <= '0;
      req_month_tens <= '0;
      req_month_ones <= '0;
      req_year_tens  <= '0;
      req_year_ones  <= '0;
      req_position   <= '0;
      no_gaps      = 1'b0;
      stored       = 0;
      random_items = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // query on an empty store
      offer(query_req(0));
      offer(date_req(0, 0, 0, 0, 0, 0));
      // all digits fifteen, key wraps past the key width
      offer(date_req(15, 15, 15, 15, 15, 15));
      offer(date_req(9, 9, 9, 9, 9, 9));
      // equal keys keep arrival order
      offer(date_req(0, 0, 0, 0, 0, 0));
      offer(date_req(15, 15, 15, 15, 15, 15));
      offer(date_req(0, 1, 0, 1, 2, 5));
      offer(plain_req(OP_RESERVED));
      for (int i = 0; i <= 6; i++) offer(query_req(i));
      offer(query_req(511));
      offer(plain_req(sdks_pkg::OP_CLEAR));
      offer(query_req(0));
      offer(date_req(3, 1, 1, 2, 9, 9));
      offer(query_req(0));
      offer(query_req(1));

      // fill the store past full so the extra appends are dropped
      offer(plain_req(sdks_pkg::OP_CLEAR));
      repeat (MAX_RECORDS + 4) offer(random_append());
      offer(query_req(0));
      offer(query_req(MAX_RECORDS / 2));
      offer(query_req(MAX_RECORDS - 2));
      offer(query_req(MAX_RECORDS - 1));
      repeat (20) offer(random_query());
      offer(plain_req(sdks_pkg::OP_CLEAR));

      while (random_items < 100) begin
         if (random_items >= 75) hold_go <= 1'b1;
         no_gaps = (random_items >= 10 && random_items < 70);
         if ($urandom_range(99) < 80) begin
            if ($urandom_range(3) == 0) begin
               offer(plain_req(sdks_pkg::OP_CLEAR));
               random_items++;
            end
            n = $urandom_range(1, 24);
            repeat (n) begin
               offer(random_append());
               random_items++;
            end
            n = $urandom_range(1, 16);
            repeat (n) begin
               offer(random_query());
               random_items++;
            end
         end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               r = plain_req(sdks_pkg::OP_W'($urandom_range(3)));
               offer(r);
               if (r.op != OP_RESERVED) random_items++;
            end
         end
      end
      no_gaps = 1'b0;
      req_valid <= 1'b0;

      while (answers_waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
